// ----- hw/rtl/aes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// S-box tables, GF(2^8) helpers and round functions for the block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int NUM_ROUNDS_DEF = 10;
  localparam int BLOCK_W = 128;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_ENCRYPT = 2'd1,
    KIND_DECRYPT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] a2, a4, a8;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    gmul = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^
           (b[2] ? a4 : 8'h00) ^ (b[3] ? a8 : 8'h00);
  endfunction

  // Full GF(2^8) product of a and b by shift-and-add, reduced with 8'h1b.
  function automatic logic [7:0] gf_full(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = xt(acc);
      if (a[i]) acc = acc ^ b;
    end
    gf_full = acc;
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] p, r;
    p = x;
    r = 8'h01;
    for (int k = 0; k < 7; k++) begin
      p = gf_full(p, p);
      r = gf_full(r, p);
    end
    if (x == 8'h00) r = 8'h00;
    sbox_calc = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^
                {r[3:0], r[7:4]} ^ 8'h63;
  endfunction

  typedef logic [7:0] box_t [256];

  function automatic box_t build_fwd();
    box_t b;
    for (int v = 0; v < 256; v++) b[v] = sbox_calc(v[7:0]);
    return b;
  endfunction

  function automatic box_t build_inv();
    box_t b;
    for (int v = 0; v < 256; v++) b[sbox_calc(v[7:0])] = v[7:0];
    return b;
  endfunction

  localparam box_t FWD_BOX = build_fwd();
  localparam box_t INV_BOX = build_inv();

  // Byte i of the block sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] gb(input logic [127:0] s, input int i);
    gb = s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r+4*c] = FWD_BOX[gb(s, r + 4*((c+r)&3))];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) begin
        if (last) o[127-8*(4*c+i) -: 8] = t[4*c+i];
        else o[127-8*(4*c+i) -: 8] =
          gmul(t[4*c+i], 4'h2) ^ gmul(t[4*c+((i+1)&3)], 4'h3) ^
          t[4*c+((i+2)&3)] ^ t[4*c+((i+3)&3)];
      end
    enc_round = o;
  endfunction

  // Inverse ShiftRows and SubBytes; the key is added outside.
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(r + 4*((c+r)&3)) -: 8] = INV_BOX[gb(s, r+4*c)];
    dec_sub = o;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        o[127-8*(4*c+i) -: 8] =
          gmul(gb(s, 4*c+i), 4'he) ^ gmul(gb(s, 4*c+((i+1)&3)), 4'hb) ^
          gmul(gb(s, 4*c+((i+2)&3)), 4'hd) ^ gmul(gb(s, 4*c+((i+3)&3)), 4'h9);
    inv_mix = o;
  endfunction

endpackage

// ----- hw/rtl/aes128_block_cipher.sv -----
`timescale 1ns / 1ps
// An accepted encrypt or decrypt beat reads its first key while idle; then one round is
// applied per cycle from the key store's read port, and the result waits in ST_OUT.
// No new beat is taken until the result enters the output register; a load beat stays idle.
// Reset clears the control state only; round keys are undefined until loaded.
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Round keys live in a RAM; one round is applied per cycle as keys stream out.
// ----------------------------------------------------------------------------
module aes128_block_cipher #(
  parameter int NUM_ROUNDS = aes_pkg::NUM_ROUNDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // kind
  input  logic [135:0] in_tdata,   // key_round[3:0], data_high[67:4], data_low[131:68], pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tuser,  // was_decrypt
  output logic [127:0] out_tdata   // result_high[63:0], result_low[127:64]
);
  import aes_pkg::*;

  localparam int SLOTS = NUM_ROUNDS + 1;
  localparam int AW = $clog2(SLOTS);

  state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;      // rounds applied so far
  logic [127:0] st_r, st_nxt;
  logic dec_r, dec_nxt;
  logic [127:0] res_r, res_nxt;
  logic vld_r, vld_nxt;

  logic we;
  logic [AW-1:0] raddr;
  logic [127:0] key;
  logic [127:0] blk;
  logic [3:0] slot;

  assign slot = in_tdata[3:0];
  assign blk = {in_tdata[67:4], in_tdata[131:68]};
  assign in_tready = (state_r == ST_IDLE);
  assign we = in_tvalid && in_tready && (kind_t'(in_tuser) == KIND_LOAD) &&
              (slot < 4'(SLOTS));

  aes_ram #(.WIDTH(BLOCK_W), .DEPTH(SLOTS)) u_keys (
    .clk(clk), .we(we), .waddr(slot[AW-1:0]), .wdata(blk),
    .raddr(raddr), .rdata(key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r <= vld_nxt;
    end
    cnt_r <= cnt_nxt;
    st_r <= st_nxt;
    dec_r <= dec_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    logic [127:0] x;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    st_nxt = st_r;
    dec_nxt = dec_r;
    res_nxt = res_r;
    vld_nxt = vld_r;
    raddr = '0;
    x = '0;
    if (vld_r && out_tready) vld_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        raddr = (kind_t'(in_tuser) == KIND_DECRYPT) ? AW'(NUM_ROUNDS) : '0;
        if (in_tvalid && (kind_t'(in_tuser) == KIND_ENCRYPT ||
                          kind_t'(in_tuser) == KIND_DECRYPT)) begin
          st_nxt = blk;
          dec_nxt = (kind_t'(in_tuser) == KIND_DECRYPT);
          cnt_nxt = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // Key for step cnt_r is on the read port; fetch the next one.
        raddr = dec_r ? AW'(NUM_ROUNDS - 1) - cnt_r : cnt_r + AW'(1);
        if (cnt_r == '0) x = st_r ^ key;
        else if (!dec_r) x = enc_round(st_r, cnt_r == AW'(NUM_ROUNDS)) ^ key;
        else begin
          x = dec_sub(st_r) ^ key;
          if (cnt_r != AW'(NUM_ROUNDS)) x = inv_mix(x);
        end
        st_nxt = x;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(NUM_ROUNDS)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!vld_r || out_tready) begin
          res_nxt = st_r;
          vld_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic res_dec_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!vld_r || out_tready)) res_dec_r <= dec_r;
  end

  assign out_tvalid = vld_r;
  assign out_tdata = {res_r[63:0], res_r[127:64]};
  assign out_tuser = res_dec_r;

`ifndef ASSERT_OFF
  a_busy_noready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !in_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_tready) |=> (vld_r && $stable(res_r))) else $error("result lost");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r <= AW'(NUM_ROUNDS))) else $error("round overrun");
`endif
endmodule

// ----- hw/rtl/aes_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- test/aes128_block_cipher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Loads round keys, then streams encrypt and decrypt blocks through the core
// under bursty input and stalling output. Every result beat is checked
// against a behavioral cipher that runs on its own copy of the key store.
// ----------------------------------------------------------------------------
module aes128_block_cipher_tb;
  import aes_pkg::*;

  localparam int KEY_SLOTS   = 11;
  localparam int RANDOM_BEATS = 1800;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    kind_t       kind;
    logic [3:0]  slot;
    logic [63:0] hi;
    logic [63:0] lo;
  } beat_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        dec;
  } block_out_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;   // kind
  logic [135:0] in_tdata = '0;   // key_round[3:0], data_high[67:4], data_low[131:68], pad
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         out_tuser;       // was_decrypt
  logic [127:0] out_tdata;       // result_high[63:0], result_low[127:64]

  aes128_block_cipher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral cipher state.
  logic [7:0]   sub_fwd [256];
  logic [7:0]   sub_inv [256];
  logic [127:0] key_store [KEY_SLOTS];
  block_out_t   pending_blocks [$];
  beat_t        stimulus [$];

  int errors = 0;
  int blocks_checked = 0;
  int enc_seen = 0;
  int dec_seen = 0;
  int loads_sent = 0;
  int ignored_sent = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;
  bit hold_done = 1'b0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? 8'h1b : 8'h00);
      if (a[i]) acc ^= b;
    end
    return acc;
  endfunction

  // Runs the full forward or inverse cipher over the current key store.
  // Byte i of the block is bits 127-8i downto 120-8i, column-major.
  function automatic logic [127:0] run_cipher(logic [127:0] blk, bit decrypt);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] coef [4];
    logic [127:0] res;
    int rnd;
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
    if (decrypt) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int step = 0; step <= 10; step++) begin
      rnd = decrypt ? 10 - step : step;
      if (step != 0) begin
        // Row shift and byte substitution.
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            if (decrypt) tmp[r + 4*((c+r)&3)] = sub_inv[st[r + 4*c]];
            else tmp[r + 4*c] = sub_fwd[st[r + 4*((c+r)&3)]];
          end
        st = tmp;
        if (!decrypt && step != 10) begin
          for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) begin
              tmp[4*c+i] = 8'h00;
              for (int j = 0; j < 4; j++)
                tmp[4*c+i] ^= gf_mul(coef[(j-i+4)&3], st[4*c+j]);
            end
          st = tmp;
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= key_store[rnd][127-8*i -: 8];
      // The inverse column mix follows the key addition on the way back.
      if (decrypt && step != 0 && step != 10) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) begin
            tmp[4*c+i] = 8'h00;
            for (int j = 0; j < 4; j++)
              tmp[4*c+i] ^= gf_mul(coef[(j-i+4)&3], st[4*c+j]);
          end
        st = tmp;
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH block %0d %s: got %h expected %h", blocks_checked, field, got, want);
    errors++;
  endtask

  task automatic add_beat(kind_t kind, logic [3:0] slot, logic [63:0] hi, logic [63:0] lo);
    beat_t b;
    b.kind = kind;
    b.slot = slot;
    b.hi = hi;
    b.lo = lo;
    stimulus.push_back(b);
  endtask

  // Substitution tables from the multiplicative inverse and the affine map.
  initial begin
    logic [7:0] x, p, r, s;
    for (int v = 0; v < 256; v++) begin
      x = v[7:0];
      p = x;
      r = 8'h01;
      for (int k = 0; k < 7; k++) begin
        p = gf_mul(p, p);
        r = gf_mul(r, p);
      end
      if (x == 8'h00) r = 8'h00;
      s = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^
          {r[3:0], r[7:4]} ^ 8'h63;
      sub_fwd[v] = s;
      sub_inv[s] = x;
    end
    for (int i = 0; i < KEY_SLOTS; i++) key_store[i] = '0;
  end

  // Input acceptance updates the key store or queues the expected block.
  always @(posedge clk) begin
    block_out_t e;
    logic [127:0] r;
    if (rst_n && in_tvalid && in_tready) begin
      case (kind_t'(in_tuser))
        KIND_LOAD: begin
          if (in_tdata[3:0] < KEY_SLOTS)
            key_store[in_tdata[3:0]] = {in_tdata[67:4], in_tdata[131:68]};
        end
        KIND_ENCRYPT, KIND_DECRYPT: begin
          r = run_cipher({in_tdata[67:4], in_tdata[131:68]}, in_tuser == KIND_DECRYPT);
          e.hi = r[127:64];
          e.lo = r[63:0];
          e.dec = (in_tuser == KIND_DECRYPT);
          pending_blocks.push_back(e);
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    block_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[63:0], 64'h0);
      end else begin
        e = pending_blocks.pop_front();
        if (out_tdata[63:0] !== e.hi) report_mismatch("result_high", out_tdata[63:0], e.hi);
        if (out_tdata[127:64] !== e.lo)
          report_mismatch("result_low", out_tdata[127:64], e.lo);
        if (out_tuser !== e.dec) report_mismatch("was_decrypt", 64'(out_tuser), 64'(e.dec));
        if (e.dec) dec_seen++;
        else enc_seen++;
      end
      blocks_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: one long hold-off once traffic is flowing, otherwise shifting
  // stall patterns, including stretches of steady readiness.
  initial begin
    int mode;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && blocks_checked >= 40) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Sender: builds the stimulus list, then drives it in bursts.
  initial begin
    logic [63:0] h, l;
    int pick, burst, gap;
    // Directed part: all key slots first so no block reads an empty slot.
    for (int s = 0; s < KEY_SLOTS; s++)
      add_beat(KIND_LOAD, s[3:0], {$urandom, $urandom}, {$urandom, $urandom});
    add_beat(KIND_LOAD, 4'd11, '1, '1);            // slot out of range
    add_beat(KIND_LOAD, 4'd15, 64'h0, '1);         // slot out of range
    add_beat(KIND_NONE, 4'd0, '1, '1);             // unknown kind
    add_beat(KIND_ENCRYPT, 4'd0, 64'h0, 64'h0);
    add_beat(KIND_ENCRYPT, 4'd15, '1, '1);
    add_beat(KIND_DECRYPT, 4'd0, 64'h0, 64'h0);
    add_beat(KIND_DECRYPT, 4'd15, '1, '1);
    add_beat(KIND_ENCRYPT, 4'd5, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    add_beat(KIND_LOAD, 4'd10, '1, '1);
    add_beat(KIND_LOAD, 4'd0, 64'h0, 64'h0);
    add_beat(KIND_DECRYPT, 4'd10, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    // Random part: mostly cipher blocks, some key reloads and ignored beats.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      pick = $urandom_range(0, 99);
      h = {$urandom, $urandom};
      l = {$urandom, $urandom};
      if ($urandom_range(0, 19) == 0) h = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 19) == 0) l = $urandom_range(0, 1) ? '1 : '0;
      if (pick < 10) add_beat(KIND_LOAD, 4'($urandom_range(0, 10)), h, l);
      else if (pick < 12) add_beat(KIND_LOAD, 4'($urandom_range(11, 15)), h, l);
      else if (pick < 14) add_beat(KIND_NONE, 4'($urandom_range(0, 15)), h, l);
      else if (pick < 57) add_beat(KIND_ENCRYPT, 4'($urandom_range(0, 15)), h, l);
      else add_beat(KIND_DECRYPT, 4'($urandom_range(0, 15)), h, l);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst = $urandom_range(1, 12);
    foreach (stimulus[i]) begin
      in_tvalid <= 1'b1;
      in_tuser <= stimulus[i].kind;
      in_tdata <= {4'b0, stimulus[i].lo, stimulus[i].hi, stimulus[i].slot};
      if (stimulus[i].kind == KIND_LOAD) loads_sent++;
      else if (stimulus[i].kind == KIND_NONE) ignored_sent++;
      do @(posedge clk); while (!in_tready);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    // Let the last accepted beat reach the predictor before draining.
    @(posedge clk);
    wait (pending_blocks.size() == 0);
    repeat (30) @(posedge clk);
    $display("Covered %0d beats: %0d key loads, %0d ignored, %0d blocks checked",
             stimulus.size(), loads_sent, ignored_sent, blocks_checked);
    $display("(%0d encrypt, %0d decrypt), with one long output hold-off.",
             enc_seen, dec_seen);
    if (errors == 0 && pending_blocks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_blocks.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
